// File: hdl/tph_pkg.sv
package tph_pkg;

   // widths fixed by the register and field layout
   localparam int CFG_W   = 10;
   localparam int LOG_W   = 4;
   localparam int HASH_W  = 10;
   localparam int ROW_W   = 11;
   localparam int ABS_W   = 16;
   localparam int TP_W    = 6;
   localparam int J_W     = 4;
   localparam int SLOT_W  = 12;
   localparam int KEY_W   = 64;

   // tiny pointer layout
   localparam int TP_SEC_BIT = 4;
   localparam int TP_H3_BIT  = 5;
   localparam logic [TP_W-1:0] TP_SLOT_MASK = 6'h0F;

   // hash constants
   localparam logic [63:0] H1_MUL_A = 64'hff51afd7ed558ccd;
   localparam logic [63:0] H1_MUL_B = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] H2_MUL   = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] H3_MUL   = 64'h6c62272e07bb0142;

   // register reset values
   localparam logic [CFG_W-1:0] PRIMARY_RESET   = 10'd448;
   localparam logic [CFG_W-1:0] SECONDARY_RESET = 10'd64;
   localparam logic [LOG_W-1:0] LOG2_RESET      = 4'd12;

   // register indexes
   localparam logic [1:0] CSR_PRIMARY   = 2'd0;
   localparam logic [1:0] CSR_SECONDARY = 2'd1;
   localparam logic [1:0] CSR_LOG2      = 2'd2;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED   = 3'd0,
      ST_DUPLICATE  = 3'd1,
      ST_POOL_FULL  = 3'd2,
      ST_FOUND      = 3'd3,
      ST_NOT_FOUND  = 3'd4,
      ST_TABLE_FULL = 3'd5
   } status_type;

   // which hash, and which pool bucket row
   typedef enum logic [1:0] {
      SEL_PRI = 2'd0,
      SEL_H2  = 2'd1,
      SEL_H3  = 2'd2
   } sel_type;

   typedef struct packed {
      logic              used;
      logic [KEY_W-1:0]  khi;
      logic [KEY_W-1:0]  klo;
      logic [TP_W-1:0]   tp;
   } entry_type;

   typedef struct packed {
      logic       clr_en;
      logic       load_req;
      logic       hash_start;
      sel_type    hash_sel;
      logic       pool_rd;
      sel_type    pool_sel;
      logic       pri_take;
      logic       s2_latch;
      logic       sec_take;
      logic       probe_init;
      logic       probe_next;
      logic       key_write;
      logic       pool_free;
      logic       fin;
      status_type fin_code;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic hash_done;
      logic is_lookup;
      logic pri_free;
      logic sec_free;
      logic probe_empty;
      logic probe_match;
      logic probe_last;
   } stat_type;

endpackage

// File: hdl/tiny_pointer_hash_table_top.sv
// Tiny-pointer hash table. A request (start while busy is low) is an insert or a
// lookup of a 128-bit key; each request gives exactly one response, shown for a
// single cycle on rsp_valid, and the receiver cannot stall it. After reset the
// block clears its key table and pool bitmap, one entry a cycle, with busy high;
// register writes are taken at any time. A request then runs the
// three hashes, which run one after another through a single 32x32 multiplier
// and a four-bit-a-cycle remainder unit, then up to three pool bucket reads on
// insert, then probes the key table one slot at a time through the one
// read port of the key memory. The user must write registers only while busy
// is low; the block itself does not enforce this.
module tiny_pointer_hash_table_top #(
   parameter int TABLE_SLOTS  = 4096,
   parameter int BUCKET_SLOTS = 8,
   parameter int POOL_SLOTS   = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [tph_pkg::KEY_W-1:0]     req_key_lo,
   input  logic [tph_pkg::KEY_W-1:0]     req_key_hi,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [tph_pkg::TP_W-1:0]      rsp_tptr,
   output logic [tph_pkg::SLOT_W-1:0]    rsp_pool_slot,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [tph_pkg::CFG_W-1:0]     csr_wdata
);

   tph_pkg::cmd_type  cmd;
   tph_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   tph_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   tph_datapath #(
      .TABLE_SLOTS  (TABLE_SLOTS),
      .BUCKET_SLOTS (BUCKET_SLOTS),
      .POOL_SLOTS   (POOL_SLOTS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_action),
      .req_key_lo    (req_key_lo),
      .req_key_hi    (req_key_hi),
      .csr_we        (csr_valid & csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_tptr      (rsp_tptr),
      .rsp_pool_slot (rsp_pool_slot)
   );

endmodule

// File: hdl/tph_ram.sv
module tph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/tph_hash.sv
module tph_hash (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  tph_pkg::sel_type              kind,
   input  logic [tph_pkg::KEY_W-1:0]     operand,
   input  logic [tph_pkg::HASH_W-1:0]    modulus,
   output logic                          done,
   output logic [tph_pkg::HASH_W-1:0]    result
);

   typedef enum logic [3:0] {
      HS_IDLE = 4'b0001,
      HS_MUL  = 4'b0010,
      HS_MIX  = 4'b0100,
      HS_MOD  = 4'b1000
   } hs_state_type;

   hs_state_type                   state_ff, state_in;
   logic                           done_ff, done_in;
   logic [63:0]                    v_ff, v_in;
   logic [63:0]                    acc_ff, acc_in;
   logic [63:0]                    prod_ff, prod_in;
   logic [3:0]                     cnt_ff, cnt_in;
   logic                           round_ff, round_in;
   tph_pkg::sel_type               kind_ff, kind_in;
   logic [tph_pkg::HASH_W-1:0]     m_ff, m_in;
   logic [tph_pkg::HASH_W-1:0]     r_ff, r_in;

   logic [63:0] mul_c;
   logic [31:0] op_a, op_b;

   always_comb begin
      case (kind_ff)
         tph_pkg::SEL_PRI: mul_c = round_ff ? tph_pkg::H1_MUL_B : tph_pkg::H1_MUL_A;
         tph_pkg::SEL_H2:  mul_c = tph_pkg::H2_MUL;
         default:          mul_c = tph_pkg::H3_MUL;
      endcase
      // 64-bit product low half from three 32x32 partials
      op_a = (cnt_ff == 4'd2) ? v_ff[63:32] : v_ff[31:0];
      op_b = (cnt_ff == 4'd1) ? mul_c[63:32] : mul_c[31:0];
   end

   always_comb begin
      logic [10:0]                t;
      logic [tph_pkg::HASH_W-1:0] rr;
      state_in = state_ff;
      done_in  = 1'b0;
      v_in     = v_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      round_in = round_ff;
      kind_in  = kind_ff;
      m_in     = m_ff;
      r_in     = r_ff;
      t        = '0;
      rr       = r_ff;
      case (state_ff)
         HS_IDLE: begin
            if (start) begin
               v_in     = (kind == tph_pkg::SEL_H2) ? (operand ^ (operand >> 31))
                                                    : (operand ^ (operand >> 33));
               kind_in  = kind;
               m_in     = modulus;
               round_in = 1'b0;
               cnt_in   = '0;
               state_in = HS_MUL;
            end
         end
         HS_MUL: begin
            if (cnt_ff != 4'd3) begin
               prod_in = {32'b0, op_a} * {32'b0, op_b};
            end
            if (cnt_ff == 4'd1) begin
               acc_in = prod_ff;
            end else if (cnt_ff != 4'd0) begin
               acc_in = acc_ff + {prod_ff[31:0], 32'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               state_in = HS_MIX;
            end
         end
         HS_MIX: begin
            v_in   = (kind_ff == tph_pkg::SEL_H2) ? (acc_ff ^ (acc_ff >> 31))
                                                  : (acc_ff ^ (acc_ff >> 33));
            cnt_in = '0;
            if (kind_ff == tph_pkg::SEL_PRI && !round_ff) begin
               round_in = 1'b1;
               state_in = HS_MUL;
            end else begin
               r_in     = '0;
               state_in = HS_MOD;
            end
         end
         HS_MOD: begin
            // restoring remainder, four bits a cycle
            for (int i = 0; i < 4; i++) begin
               t = {rr, v_ff[63-i]};
               if (t >= {1'b0, m_ff}) begin
                  t = t - {1'b0, m_ff};
               end
               rr = t[tph_pkg::HASH_W-1:0];
            end
            r_in   = rr;
            v_in   = {v_ff[59:0], 4'b0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               done_in  = 1'b1;
               state_in = HS_IDLE;
            end
         end
         default: begin
            state_in = HS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      cnt_ff   <= cnt_in;
      round_ff <= round_in;
      kind_ff  <= kind_in;
      m_ff     <= m_in;
      r_ff     <= r_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

// File: hdl/tph_datapath.sv
module tph_datapath #(
   parameter int TABLE_SLOTS  = 4096,
   parameter int BUCKET_SLOTS = 8,
   parameter int POOL_SLOTS   = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_action,
   input  logic [tph_pkg::KEY_W-1:0]     req_key_lo,
   input  logic [tph_pkg::KEY_W-1:0]     req_key_hi,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [tph_pkg::CFG_W-1:0]     csr_wdata,
   input  tph_pkg::cmd_type              cmd,
   output tph_pkg::stat_type             stat,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [tph_pkg::TP_W-1:0]      rsp_tptr,
   output logic [tph_pkg::SLOT_W-1:0]    rsp_pool_slot
);

   localparam int IDX_W  = $clog2(TABLE_SLOTS);
   localparam int ROWS   = (POOL_SLOTS + BUCKET_SLOTS - 1) / BUCKET_SLOTS;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CLR_N  = (TABLE_SLOTS > ROWS) ? TABLE_SLOTS : ROWS;
   localparam int CLR_W  = $clog2(CLR_N);
   localparam int LMAX   = $clog2(TABLE_SLOTS + 1) - 1;
   localparam int ENT_W  = $bits(tph_pkg::entry_type);

   localparam int ROW_W  = tph_pkg::ROW_W;
   localparam int ABS_W  = tph_pkg::ABS_W;
   localparam int J_W    = tph_pkg::J_W;
   localparam int TP_W   = tph_pkg::TP_W;
   localparam int HASH_W = tph_pkg::HASH_W;

   function automatic logic [BUCKET_SLOTS-1:0] free_mask(input logic [ROW_W-1:0] row,
                                                         input logic [BUCKET_SLOTS-1:0] used);
      logic [ABS_W-1:0]        base;
      logic [BUCKET_SLOTS-1:0] f;
      base = ABS_W'(row) * ABS_W'(BUCKET_SLOTS);
      for (int j = 0; j < BUCKET_SLOTS; j++) begin
         f[j] = !used[j] && ((32'(base) + 32'(j)) < 32'(POOL_SLOTS));
      end
      return f;
   endfunction

   function automatic logic [J_W-1:0] first_free(input logic [BUCKET_SLOTS-1:0] m);
      logic [J_W-1:0] j;
      j = '0;
      for (int i = BUCKET_SLOTS - 1; i >= 0; i--) begin
         if (m[i]) begin
            j = J_W'(i);
         end
      end
      return j;
   endfunction

   function automatic logic [J_W:0] pop_count(input logic [BUCKET_SLOTS-1:0] m);
      logic [J_W:0] c;
      c = '0;
      for (int i = 0; i < BUCKET_SLOTS; i++) begin
         c = c + (J_W+1)'(m[i]);
      end
      return c;
   endfunction

   function automatic logic [ABS_W-1:0] slot_of(input logic [ROW_W-1:0] row,
                                                input logic [J_W-1:0] j);
      return ABS_W'(row) * ABS_W'(BUCKET_SLOTS) + ABS_W'(j);
   endfunction

   // configuration
   logic [tph_pkg::CFG_W-1:0] prim_ff, sec_ff;
   logic [tph_pkg::LOG_W-1:0] lg_ff;
   logic [HASH_W-1:0]         peff, seff;

   // request
   logic                      act_ff;
   logic [63:0]               klo_ff, khi_ff;
   tph_pkg::sel_type          hsel_ff;
   logic [HASH_W-1:0]         h1_ff, h2_ff, h3_ff;

   // pool allocation
   logic [ROW_W-1:0]          pool_row_ff, row2_ff, alloc_row_ff;
   logic [BUCKET_SLOTS-1:0]   used2_ff, alloc_used_ff;
   logic [TP_W-1:0]           alloc_tp_ff;
   logic [ABS_W-1:0]          alloc_abs_ff;

   // probing
   logic [IDX_W-1:0]          idx_ff, n_ff;
   logic [CLR_W-1:0]          clr_cnt_ff;

   logic                      rsp_valid_ff;
   logic [2:0]                status_ff;
   logic [TP_W-1:0]           tp_ff;
   logic [tph_pkg::SLOT_W-1:0] slot_ff;

   logic                      hash_done;
   logic [HASH_W-1:0]         hash_result;
   logic [63:0]               hash_op;
   logic [HASH_W-1:0]         hash_mod;

   logic [ROW_W-1:0]          rd_row;
   logic [BUCKET_SLOTS-1:0]   pool_rdata, pool_wdata;
   logic [ROW_AW-1:0]         pool_waddr;
   logic                      pool_we;
   logic [BUCKET_SLOTS-1:0]   free_cur, free2, ch_free, ch_used;
   logic [ROW_W-1:0]          ch_row;
   logic                      use3;
   logic [J_W-1:0]            jp, js;

   logic [IDX_W:0]            mask_w;
   logic [IDX_W-1:0]          mask;
   logic [4:0]                leff;

   tph_pkg::entry_type        ent, ent_w;
   logic [ENT_W-1:0]          key_rdata;
   logic                      key_we;
   logic [IDX_W-1:0]          key_waddr;
   logic [ROW_W-1:0]          dec_row;
   logic [ABS_W-1:0]          dec_slot;

   assign peff = (prim_ff == '0) ? HASH_W'(1) : prim_ff;
   assign seff = (sec_ff == '0) ? HASH_W'(1) : sec_ff;

   assign hash_op  = cmd.load_req ? req_key_lo
                   : ((cmd.hash_sel == tph_pkg::SEL_H3) ? khi_ff : klo_ff);
   assign hash_mod = (cmd.hash_sel == tph_pkg::SEL_PRI) ? peff : seff;

   tph_hash u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.hash_start),
      .kind    (cmd.hash_sel),
      .operand (hash_op),
      .modulus (hash_mod),
      .done    (hash_done),
      .result  (hash_result)
   );

   // probe mask, table size clamped to what the key memory holds
   always_comb begin
      leff   = ({1'b0, lg_ff} > 5'(LMAX)) ? 5'(LMAX) : {1'b0, lg_ff};
      mask_w = ((IDX_W+1)'(1) << leff) - (IDX_W+1)'(1);
      mask   = mask_w[IDX_W-1:0];
   end

   always_comb begin
      case (cmd.pool_sel)
         tph_pkg::SEL_PRI: rd_row = {1'b0, h1_ff};
         tph_pkg::SEL_H2:  rd_row = {1'b0, peff} + {1'b0, h2_ff};
         default:          rd_row = {1'b0, peff} + {1'b0, h3_ff};
      endcase
   end

   // two-choice between the secondary buckets, ties to h2
   always_comb begin
      free_cur = free_mask(pool_row_ff, pool_rdata);
      free2    = free_mask(row2_ff, used2_ff);
      use3     = pop_count(free_cur) > pop_count(free2);
      ch_free  = use3 ? free_cur : free2;
      ch_used  = use3 ? pool_rdata : used2_ff;
      ch_row   = use3 ? pool_row_ff : row2_ff;
      jp       = first_free(free_cur);
      js       = first_free(ch_free);
   end

   always_comb begin
      pool_we    = 1'b0;
      pool_waddr = ROW_AW'(alloc_row_ff);
      pool_wdata = alloc_used_ff & ~(BUCKET_SLOTS'(1) << alloc_tp_ff[J_W-1:0]);
      if (cmd.clr_en) begin
         pool_we    = 32'(clr_cnt_ff) < 32'(ROWS);
         pool_waddr = ROW_AW'(clr_cnt_ff);
         pool_wdata = '0;
      end else if (cmd.pri_take) begin
         pool_we    = 1'b1;
         pool_waddr = ROW_AW'(pool_row_ff);
         pool_wdata = pool_rdata | (BUCKET_SLOTS'(1) << jp);
      end else if (cmd.sec_take) begin
         pool_we    = 1'b1;
         pool_waddr = ROW_AW'(ch_row);
         pool_wdata = ch_used | (BUCKET_SLOTS'(1) << js);
      end else if (cmd.pool_free) begin
         pool_we    = 1'b1;
      end
   end

   tph_ram #(
      .WIDTH (BUCKET_SLOTS),
      .DEPTH (ROWS)
   ) u_pool_ram (
      .clock (clock),
      .we    (pool_we),
      .waddr (pool_waddr),
      .wdata (pool_wdata),
      .raddr (ROW_AW'(rd_row)),
      .rdata (pool_rdata)
   );

   always_comb begin
      ent_w.used = 1'b1;
      ent_w.khi  = khi_ff;
      ent_w.klo  = klo_ff;
      ent_w.tp   = alloc_tp_ff;
      key_we     = cmd.key_write;
      key_waddr  = idx_ff;
      if (cmd.clr_en) begin
         ent_w     = '0;
         key_we    = 32'(clr_cnt_ff) < 32'(TABLE_SLOTS);
         key_waddr = IDX_W'(clr_cnt_ff);
      end
   end

   tph_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (ent_w),
      .raddr (idx_ff),
      .rdata (key_rdata)
   );

   assign ent = key_rdata;

   // stored tiny pointer back to an absolute slot, with current registers
   always_comb begin
      if (!ent.tp[tph_pkg::TP_SEC_BIT]) begin
         dec_row = {1'b0, h1_ff};
      end else if (ent.tp[tph_pkg::TP_H3_BIT]) begin
         dec_row = {1'b0, peff} + {1'b0, h3_ff};
      end else begin
         dec_row = {1'b0, peff} + {1'b0, h2_ff};
      end
      dec_slot = slot_of(dec_row, J_W'(ent.tp & tph_pkg::TP_SLOT_MASK));
   end

   always_comb begin
      stat.clr_done    = 32'(clr_cnt_ff) == 32'(CLR_N - 1);
      stat.hash_done   = hash_done;
      stat.is_lookup   = act_ff == tph_pkg::ACT_LOOKUP;
      stat.pri_free    = |free_cur;
      stat.sec_free    = |ch_free;
      stat.probe_empty = !ent.used;
      stat.probe_match = (ent.klo == klo_ff) && (ent.khi == khi_ff);
      stat.probe_last  = n_ff == mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_ff      <= tph_pkg::PRIMARY_RESET;
         sec_ff       <= tph_pkg::SECONDARY_RESET;
         lg_ff        <= tph_pkg::LOG2_RESET;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tph_pkg::CSR_PRIMARY:   prim_ff <= csr_wdata;
               tph_pkg::CSR_SECONDARY: sec_ff  <= csr_wdata;
               tph_pkg::CSR_LOG2:      lg_ff   <= csr_wdata[tph_pkg::LOG_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clr_en) begin
            clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
         end
         rsp_valid_ff <= cmd.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= req_action;
         klo_ff <= req_key_lo;
         khi_ff <= req_key_hi;
      end
      if (cmd.hash_start) begin
         hsel_ff <= cmd.hash_sel;
      end
      if (hash_done) begin
         case (hsel_ff)
            tph_pkg::SEL_PRI: h1_ff <= hash_result;
            tph_pkg::SEL_H2:  h2_ff <= hash_result;
            default:          h3_ff <= hash_result;
         endcase
      end
      if (cmd.pool_rd) begin
         pool_row_ff <= rd_row;
      end
      if (cmd.s2_latch) begin
         row2_ff  <= pool_row_ff;
         used2_ff <= pool_rdata;
      end
      if (cmd.pri_take) begin
         alloc_row_ff  <= pool_row_ff;
         alloc_used_ff <= pool_wdata;
         alloc_tp_ff   <= TP_W'(jp);
         alloc_abs_ff  <= slot_of(pool_row_ff, jp);
      end
      if (cmd.sec_take) begin
         alloc_row_ff  <= ch_row;
         alloc_used_ff <= pool_wdata;
         alloc_tp_ff   <= {use3, 1'b1, js};
         alloc_abs_ff  <= slot_of(ch_row, js);
      end
      if (cmd.probe_init) begin
         idx_ff <= klo_ff[IDX_W-1:0] & mask;
         n_ff   <= '0;
      end else if (cmd.probe_next) begin
         idx_ff <= (idx_ff + IDX_W'(1)) & mask;
         n_ff   <= n_ff + IDX_W'(1);
      end
      if (cmd.fin) begin
         status_ff <= cmd.fin_code;
         case (cmd.fin_code)
            tph_pkg::ST_INSERTED: begin
               tp_ff   <= alloc_tp_ff;
               slot_ff <= alloc_abs_ff[tph_pkg::SLOT_W-1:0];
            end
            tph_pkg::ST_FOUND: begin
               tp_ff   <= ent.tp;
               slot_ff <= dec_slot[tph_pkg::SLOT_W-1:0];
            end
            default: begin
               tp_ff   <= '0;
               slot_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_tptr      = tp_ff;
   assign rsp_pool_slot = slot_ff;

endmodule

// File: hdl/tph_ctrl.sv
module tph_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tph_pkg::stat_type stat,
   output tph_pkg::cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_CLEAR     = 10'b0000000001,
      S_IDLE      = 10'b0000000010,
      S_H1        = 10'b0000000100,
      S_H2        = 10'b0000001000,
      S_H3        = 10'b0000010000,
      S_PRI_CHK   = 10'b0000100000,
      S_S2_CHK    = 10'b0001000000,
      S_S3_CHK    = 10'b0010000000,
      S_PROBE_RD  = 10'b0100000000,
      S_PROBE_CHK = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req   = 1'b1;
               cmd.hash_start = 1'b1;
               cmd.hash_sel   = tph_pkg::SEL_PRI;
               state_in       = S_H1;
            end
         end
         S_H1: begin
            if (stat.hash_done) begin
               cmd.hash_start = 1'b1;
               cmd.hash_sel   = tph_pkg::SEL_H2;
               state_in       = S_H2;
            end
         end
         S_H2: begin
            if (stat.hash_done) begin
               cmd.hash_start = 1'b1;
               cmd.hash_sel   = tph_pkg::SEL_H3;
               state_in       = S_H3;
            end
         end
         S_H3: begin
            if (stat.hash_done) begin
               if (stat.is_lookup) begin
                  cmd.probe_init = 1'b1;
                  state_in       = S_PROBE_RD;
               end else begin
                  cmd.pool_rd  = 1'b1;
                  cmd.pool_sel = tph_pkg::SEL_PRI;
                  state_in     = S_PRI_CHK;
               end
            end
         end
         S_PRI_CHK: begin
            if (stat.pri_free) begin
               cmd.pri_take   = 1'b1;
               cmd.probe_init = 1'b1;
               state_in       = S_PROBE_RD;
            end else begin
               cmd.pool_rd  = 1'b1;
               cmd.pool_sel = tph_pkg::SEL_H2;
               state_in     = S_S2_CHK;
            end
         end
         S_S2_CHK: begin
            cmd.s2_latch = 1'b1;
            cmd.pool_rd  = 1'b1;
            cmd.pool_sel = tph_pkg::SEL_H3;
            state_in     = S_S3_CHK;
         end
         S_S3_CHK: begin
            if (stat.sec_free) begin
               cmd.sec_take   = 1'b1;
               cmd.probe_init = 1'b1;
               state_in       = S_PROBE_RD;
            end else begin
               cmd.fin      = 1'b1;
               cmd.fin_code = tph_pkg::ST_POOL_FULL;
               state_in     = S_IDLE;
            end
         end
         S_PROBE_RD: begin
            state_in = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            if (stat.probe_empty) begin
               cmd.fin = 1'b1;
               if (stat.is_lookup) begin
                  cmd.fin_code = tph_pkg::ST_NOT_FOUND;
               end else begin
                  cmd.key_write = 1'b1;
                  cmd.fin_code  = tph_pkg::ST_INSERTED;
               end
               state_in = S_IDLE;
            end else if (stat.probe_match) begin
               cmd.fin = 1'b1;
               if (stat.is_lookup) begin
                  cmd.fin_code = tph_pkg::ST_FOUND;
               end else begin
                  cmd.pool_free = 1'b1;
                  cmd.fin_code  = tph_pkg::ST_DUPLICATE;
               end
               state_in = S_IDLE;
            end else if (stat.probe_last) begin
               // whole probe round without a hole
               cmd.fin       = 1'b1;
               cmd.fin_code  = tph_pkg::ST_TABLE_FULL;
               cmd.pool_free = !stat.is_lookup;
               state_in      = S_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_PROBE_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule
